### src/mbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int VALUE_W          = 25;
    localparam int NBITS_W          = 5;
    localparam int PEND_W           = 7;
    localparam int PCNT_W           = 3;
    localparam int ACC_MAX_W        = PEND_W + VALUE_W;
    localparam int S_TDATA_W        = 32;
    localparam int BYTE_W           = 8;
    localparam int MAX_FIELD_BITS_D = 25;
    localparam int QUEUE_DEPTH_D    = 4;

    typedef enum logic {
        OP_PUT    = 1'b0,
        OP_FINISH = 1'b1
    } mbp_op_t;

    // per-request control word carried through the queue
    typedef struct packed {
        logic [2:0] nbytes;
        logic       eos;
    } mbp_ctrl_t;

    localparam int CTRL_W = $bits(mbp_ctrl_t);

endpackage

### src/mbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_front
// Accepts put/finish requests, merges them with the pending bits and emits
// one left-aligned word of complete bytes into the queue per request that completes a byte.
// ----------------------------------------------------------------------------
module mbp_front #(
    parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_D
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_fire,
    input  mbp_pkg::mbp_op_t                       op,
    input  logic [mbp_pkg::VALUE_W-1:0]            value,
    input  logic [mbp_pkg::NBITS_W-1:0]            nbits,
    output logic                                   push,
    output logic [8*((MAX_FIELD_BITS+7)/8)-1:0]    word,
    output mbp_pkg::mbp_ctrl_t                     ctrl
);
    import mbp_pkg::*;

    localparam int ACC_W  = MAX_FIELD_BITS + PEND_W;
    localparam int NB     = ACC_W / 8;
    localparam int WORD_W = 8 * NB;

    logic [PEND_W-1:0]  pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [NBITS_W-1:0] n_clamp;
    logic [VALUE_W-1:0] value_m;
    logic [ACC_MAX_W-1:0] acc_full;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   acc_sh;
    logic [5:0]         total;
    logic [2:0]         rem;
    logic [2:0]         put_nbytes;
    logic [5:0]         put_shamt;
    logic [BYTE_W-1:0]  fin_byte;

    always_comb begin
        n_clamp   = (nbits > NBITS_W'(MAX_FIELD_BITS)) ? NBITS_W'(MAX_FIELD_BITS) : nbits;
        value_m   = value & ~({VALUE_W{1'b1}} << n_clamp);
        acc_full  = (ACC_MAX_W'(pend_bits_reg) << n_clamp) | ACC_MAX_W'(value_m);
        acc       = acc_full[ACC_W-1:0];
        total     = 6'(pend_cnt_reg) + 6'(n_clamp);
        put_nbytes = total[5:3];
        rem       = total[2:0];
        acc_sh    = acc >> rem;
        put_shamt = {3'(NB) - put_nbytes, 3'b000};
        fin_byte  = BYTE_W'(pend_bits_reg) << (4'd8 - 4'(pend_cnt_reg));

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        push           = 1'b0;
        word           = '0;
        ctrl           = '0;
        case (op)
            OP_PUT: begin
                push           = in_fire && (put_nbytes != 3'd0);
                word           = WORD_W'(acc_sh) << put_shamt;
                ctrl.nbytes    = put_nbytes;
                ctrl.eos       = 1'b0;
                pend_cnt_next  = rem;
                pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            end
            OP_FINISH: begin
                push           = in_fire && (pend_cnt_reg != '0);
                word           = WORD_W'(fin_byte) << (WORD_W - BYTE_W);
                ctrl.nbytes    = 3'd1;
                ctrl.eos       = 1'b1;
                pend_cnt_next  = '0;
                pend_bits_next = '0;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (in_fire) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

### src/mbp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_fifo
// Short synchronous queue between the front and back parts.
// ----------------------------------------------------------------------------
module mbp_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = mbp_pkg::QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              ready,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              valid
);
    import mbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### src/mbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_back
// Takes byte words from the queue and sends them one byte per cycle, while
// m_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module mbp_back #(
    parameter int WORD_W = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    input  logic [WORD_W-1:0]       q_word,
    input  mbp_pkg::mbp_ctrl_t      q_ctrl,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [mbp_pkg::BYTE_W-1:0] m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);
    import mbp_pkg::*;

    logic [WORD_W-1:0] cur_word_reg;
    logic [2:0]        cur_left_reg;
    logic              cur_eos_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_eos_reg;
    logic              cur_valid, out_load, cur_free;

    always_comb begin
        cur_valid = (cur_left_reg != 3'd0);
        out_load  = cur_valid && (!out_valid_reg || m_tready);
        cur_free  = !cur_valid || (out_load && cur_left_reg == 3'd1);
        q_pop     = q_valid && cur_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_left_reg <= q_ctrl.nbytes;
            end else if (out_load) begin
                cur_left_reg <= cur_left_reg - 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_word_reg <= q_word;
            cur_eos_reg  <= q_ctrl.eos;
        end else if (out_load) begin
            cur_word_reg <= cur_word_reg << BYTE_W;
        end
        if (out_load) begin
            out_byte_reg <= cur_word_reg[WORD_W-1 -: BYTE_W];
            out_last_reg <= (cur_left_reg == 3'd1);
            out_eos_reg  <= cur_eos_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eos_reg;

endmodule

### src/msb_first_bit_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// Packs variable-width bit fields into a byte stream, MSB first.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects put (0) or finish (1); s_tdata carries the
// field value and its bit count. A put appends the low nbits bits of value
// (nbits clamped to MAX_FIELD_BITS); a finish zero-pads and flushes the
// pending partial byte. Output stream: the bytes of each request, first
// stream bit in bit 7; m_tlast marks the last byte caused by one input
// request, m_tuser marks the padded final byte of a finish.
// Path: a request that yields bytes is written into the queue, loaded into
// the current-word register and then into the output register behind m_tvalid.
// Throughput: one request per cycle while each yields at most one byte and
// m_tready stays high; a request yielding k bytes holds the single
// byte-per-cycle output until all k are sent. A queue of QUEUE_DEPTH byte
// words absorbs bursts; s_tready drops only when it is full.
// Reset: synchronous, clears pending bits, queue and output stage.
// A stalled m_tready holds the current byte; the front keeps accepting until
// the queue fills.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unit #(
    parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_D,
    parameter int QUEUE_DEPTH    = mbp_pkg::QUEUE_DEPTH_D
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mbp_pkg::S_TDATA_W-1:0]      s_tdata,  // value[24:0], nbits[29:25]
    input  logic                               s_tuser,  // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mbp_pkg::BYTE_W-1:0]         m_tdata,  // out_byte[7:0]
    output logic                               m_tlast,
    output logic                               m_tuser   // end_of_stream
);
    import mbp_pkg::*;

    localparam int WORD_W = 8 * ((MAX_FIELD_BITS + PEND_W) / 8);
    localparam int Q_W    = WORD_W + CTRL_W;

    logic              in_fire;
    logic              q_push, q_ready, q_pop, q_valid;
    logic [WORD_W-1:0] f_word;
    mbp_ctrl_t         f_ctrl;
    logic [Q_W-1:0]    q_rdata;
    mbp_ctrl_t         q_ctrl;
    mbp_op_t           op;

    assign s_tready = q_ready;
    assign in_fire  = s_tvalid && s_tready;
    assign op       = mbp_op_t'(s_tuser);
    assign q_ctrl   = q_rdata[CTRL_W-1:0];

    mbp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .op      (op),
        .value   (s_tdata[VALUE_W-1:0]),
        .nbits   (s_tdata[VALUE_W +: NBITS_W]),
        .push    (q_push),
        .word    (f_word),
        .ctrl    (f_ctrl)
    );

    mbp_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_word, f_ctrl}),
        .ready   (q_ready),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .valid   (q_valid)
    );

    mbp_back #(
        .WORD_W (WORD_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_word   (q_rdata[Q_W-1 -: WORD_W]),
        .q_ctrl   (q_ctrl),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_eos_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("padded final byte not marked last");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_queue_entry_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> q_ctrl.nbytes != 3'd0)
        else $error("queue entry without bytes");

endmodule
